[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, disabled during reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[sv/wwm_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard word matcher package
// Shared constants, types and character helpers of the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wwm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int POS_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_QMARK   = 8'h3F;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [1:0] {
        DEC_UNDECIDED,
        DEC_MATCH,
        DEC_NOMATCH
    } dec_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic start_needed;
        logic word_active;
        logic step_continue;
        logic item_end;
    } status_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? (c + CASE_OFFSET) : c;
    endfunction

endpackage

`default_nettype wire

[sv/wwm_ctrl.sv]
// ----------------------------------------------------------------------------
// Wildcard word matcher controller
// Sequences acceptance, pattern steps and result delivery for each item.
// ----------------------------------------------------------------------------
`default_nettype none

module wwm_ctrl import wwm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_last,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd,
    output logic    s_ready,
    output logic    m_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.start_needed) begin
                        cmd.start  = 1'b1;
                        state_next = ST_STEP;
                    end else if (status.word_active) begin
                        state_next = ST_STEP;
                    end else if (s_last) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (!status.step_continue) begin
                    state_next = status.item_end ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[sv/wwm_datapath.sv]
// ----------------------------------------------------------------------------
// Wildcard word matcher datapath
// Configuration registers, pattern snapshot with normalisation, one pattern
// step per command, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wwm_datapath import wwm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [7:0]            in_char,
    input  logic                  in_end,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic [7:0]            out_data
);

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [4:0]            pat_len_reg;

    logic [7:0]       raw     [MAX_PATTERN];
    logic [7:0]       norm    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pair;
    logic [MAX_PATTERN-1:0] star_bits;
    logic [POS_W-1:0] snap_len;
    logic [POS_W-1:0] snap_target;
    logic [2*CFG_DATA_W-1:0] cfg_word;

    logic [7:0]       pat_reg [MAX_PATTERN];
    logic [POS_W-1:0] len_reg, target_reg;
    logic [POS_W-1:0] pos_reg, cnt_reg, star_cnt_reg, pos_after_reg;
    logic             star_seen_reg, cap_pend_reg, letter_reg;
    logic [7:0]       char_after_reg, char_reg;
    logic             end_reg, out_reg;
    dec_t             dec_reg;

    logic             in_range, lit_hit, star_hit, after_hit, result;
    logic [7:0]       p, ca;
    logic [POS_W-1:0] pos_inc;

    assign cfg_word = {pat_high_reg, pat_low_reg};
    assign snap_len = (pat_len_reg > 5'(MAX_PATTERN)) ? POS_W'(MAX_PATTERN)
                                                      : POS_W'(pat_len_reg);

    // A "*?" pair never overlaps another, so every pair is rewritten in parallel.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            raw[k]       = cfg_word[k*8 +: 8];
            star_bits[k] = (POS_W'(k) < snap_len) && (raw[k] == CHAR_STAR);
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k < MAX_PATTERN - 1) begin
                pair[k] = (POS_W'(k + 1) < snap_len) && (raw[k] == CHAR_STAR) &&
                          (raw[k+1] == CHAR_QMARK);
            end else begin
                pair[k] = 1'b0;
            end
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (pair[k]) begin
                norm[k] = CHAR_QMARK;
            end else if ((k > 0) && pair[(k > 0) ? k - 1 : 0]) begin
                norm[k] = CHAR_STAR;
            end else begin
                norm[k] = raw[k];
            end
        end
    end

    assign snap_target = snap_len - POS_W'($countones(star_bits));

    assign in_range  = (pos_reg < len_reg);
    assign p         = pat_reg[pos_reg[IDX_W-1:0]];
    assign ca        = cap_pend_reg ? p : char_after_reg;
    assign lit_hit   = in_range && ((fold(p) == fold(char_reg)) || (p == CHAR_QMARK));
    assign star_hit  = in_range && !lit_hit && (p == CHAR_STAR);
    assign after_hit = (fold(char_reg) == fold(ca));
    assign pos_inc   = pos_reg + 1'b1;
    assign result    = letter_reg && ((dec_reg == DEC_MATCH) ||
                       ((dec_reg == DEC_UNDECIDED) && (cnt_reg == target_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg    <= '0;
            pat_high_reg   <= '0;
            pat_len_reg    <= '0;
            len_reg        <= '0;
            target_reg     <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            star_cnt_reg   <= '0;
            pos_after_reg  <= '0;
            star_seen_reg  <= 1'b0;
            cap_pend_reg   <= 1'b0;
            letter_reg     <= 1'b0;
            char_after_reg <= '0;
            dec_reg        <= DEC_UNDECIDED;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    REG_PAT_LOW:  pat_low_reg  <= cfg_wr_data;
                    REG_PAT_HIGH: pat_high_reg <= cfg_wr_data;
                    REG_PAT_LEN:  pat_len_reg  <= cfg_wr_data[4:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.start) begin
                pat_reg    <= norm;
                len_reg    <= snap_len;
                target_reg <= snap_target;
                letter_reg <= 1'b1;
            end
            if (cmd.step) begin
                if (cap_pend_reg) begin
                    char_after_reg <= p;
                end
                cap_pend_reg <= star_hit;
                if (lit_hit) begin
                    pos_reg <= pos_inc;
                    cnt_reg <= cnt_reg + 1'b1;
                end else if (star_hit) begin
                    pos_reg       <= pos_inc;
                    pos_after_reg <= pos_inc;
                    star_cnt_reg  <= cnt_reg;
                    star_seen_reg <= 1'b1;
                    if (pos_inc == len_reg) begin
                        dec_reg <= DEC_MATCH;
                    end
                end else if (star_seen_reg) begin
                    if (after_hit) begin
                        cnt_reg <= star_cnt_reg + 1'b1;
                        pos_reg <= pos_after_reg + 1'b1;
                    end else begin
                        cnt_reg <= star_cnt_reg;
                        pos_reg <= pos_after_reg;
                    end
                end else begin
                    dec_reg <= DEC_NOMATCH;
                end
            end
            if (cmd.emit) begin
                pos_reg        <= '0;
                cnt_reg        <= '0;
                star_cnt_reg   <= '0;
                pos_after_reg  <= '0;
                star_seen_reg  <= 1'b0;
                cap_pend_reg   <= 1'b0;
                letter_reg     <= 1'b0;
                char_after_reg <= '0;
                dec_reg        <= DEC_UNDECIDED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            char_reg <= in_char;
            end_reg  <= in_end;
        end
        if (cmd.emit) begin
            out_reg <= result;
        end
    end

    assign status.start_needed  = !letter_reg && is_letter(in_char);
    assign status.word_active   = letter_reg && (dec_reg == DEC_UNDECIDED);
    assign status.step_continue = star_hit && (pos_inc != len_reg);
    assign status.item_end      = end_reg;

    assign out_data = {7'd0, out_reg};

endmodule

`default_nettype wire

[sv/wildcard_word_matcher_top.sv]
// ----------------------------------------------------------------------------
// Wildcard word matcher, top level
// Matches streamed words against a configured pattern with '*' and '?'.
// ----------------------------------------------------------------------------
// The slave stream carries one character per item in s_tdata[7:0], with
// s_tlast high on the last character of a word. The master stream returns one
// item per word, on its last character, with the match flag in m_tdata[0].
// The pattern is loaded through the write port (index 0: characters 0 to 7,
// index 1: characters 8 to 15, index 2: length) while the block is idle; it
// is copied and normalised when the first letter of a word arrives.
// A character before the first letter, or after the word is decided, is
// taken without a pattern step, an ordinary character takes a pattern step,
// and each pattern star passed adds a further step. The last character of a
// word then passes through a delivery state before its result is valid.
// The result sits in an output register, so the following item is taken
// while it waits; when a second result is ready before the first is taken,
// input stalls until m_tready frees the register.
// Reset clears the configuration, the word state and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_word_matcher_top import wwm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] word_char
    input  logic                  s_tlast,   // word_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] matched, [7:1] zero
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cmd_t    cmd;
    status_t status;

    wwm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_last  (s_tlast),
        .m_ready (m_tready),
        .status  (status),
        .cmd     (cmd),
        .s_ready (s_tready),
        .m_valid (m_tvalid)
    );

    wwm_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_char      (s_tdata),
        .in_end       (s_tlast),
        .cmd          (cmd),
        .status       (status),
        .out_data     (m_tdata)
    );

endmodule

`default_nettype wire

[sv/wwm_checker.sv]
// ----------------------------------------------------------------------------
// Wildcard word matcher checker
// Port-level properties of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wwm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    `ASSERT_NEXT(a_out_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_data_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `ASSERT_IMPL(a_out_pad_zero, aclk, aresetn, m_tvalid, m_tdata[7:1] == 7'd0)
    `ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_tvalid && s_tready, !$rose(m_tvalid))

endmodule

bind wildcard_word_matcher_top wwm_checker u_wwm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
